FILE: design/pcp_pkg.sv
package pcp_pkg;

   localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
   localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [33:0] THREE_HALF_PI_Q30 = 34'sd5059889139;
   localparam logic signed [33:0] TWO_PI_Q30 = 34'sd6746518852;
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [22:0] ONE_Q20 = 23'sd1048576;

   localparam logic [2:0] REG_CX = 3'd0;
   localparam logic [2:0] REG_CY = 3'd1;
   localparam logic [2:0] REG_RAD = 3'd2;
   localparam logic [2:0] REG_COL = 3'd3;
   localparam logic [2:0] REG_STR = 3'd4;
   localparam logic [2:0] REG_BPP = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CORDIC,
      ST_MUL,
      ST_POINT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic restart;
      logic cordic_start;
      logic cordic_step;
      logic mul;
      logic point;
      logic div_start;
      logic div_step;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic cordic_done;
      logic idle;
   } status_type;

   function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
      case (i)
         5'd0: atan_q30 = 34'sd843314856;
         5'd1: atan_q30 = 34'sd497837829;
         5'd2: atan_q30 = 34'sd263043836;
         5'd3: atan_q30 = 34'sd133525158;
         5'd4: atan_q30 = 34'sd67021686;
         5'd5: atan_q30 = 34'sd33543515;
         5'd6: atan_q30 = 34'sd16775850;
         5'd7: atan_q30 = 34'sd8388437;
         5'd8: atan_q30 = 34'sd4194282;
         5'd9: atan_q30 = 34'sd2097149;
         default: atan_q30 = (34'sd1 <<< (6'd30 - {1'b0, i})) - 34'sd1;
      endcase
   endfunction

endpackage

FILE: design/pcp_ctrl.sv
module pcp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_restart,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  pcp_pkg::status_type status,
   output pcp_pkg::cmd_type    cmd
);

   pcp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcp_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  state_in = pcp_pkg::ST_DIV;
               end else if (!status.idle) begin
                  state_in = pcp_pkg::ST_CORDIC;
               end
            end
         end
         pcp_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = pcp_pkg::ST_CORDIC;
            end
         end
         pcp_pkg::ST_CORDIC: begin
            if (status.cordic_done) begin
               state_in = pcp_pkg::ST_MUL;
            end
         end
         pcp_pkg::ST_MUL: state_in = pcp_pkg::ST_POINT;
         pcp_pkg::ST_POINT: state_in = pcp_pkg::ST_OUT;
         pcp_pkg::ST_OUT: begin
            if (rsp_ready) begin
               state_in = pcp_pkg::ST_IDLE;
            end
         end
         default: state_in = pcp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         pcp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.restart = req_valid && req_restart;
            cmd.div_start = req_valid && req_restart;
            cmd.cordic_start = req_valid && !req_restart && !status.idle;
         end
         pcp_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.cordic_start = status.div_done;
         end
         pcp_pkg::ST_CORDIC: cmd.cordic_step = 1'b1;
         pcp_pkg::ST_MUL: cmd.mul = 1'b1;
         pcp_pkg::ST_POINT: cmd.point = 1'b1;
         pcp_pkg::ST_OUT: rsp_valid = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

FILE: design/pcp_datapath.sv
module pcp_datapath #(
   parameter int IMAGE_WIDTH  = 800,
   parameter int IMAGE_HEIGHT = 800,
   parameter int CORDIC_STEPS = 30
) (
   input  logic                clock,
   input  logic                reset,
   input  pcp_pkg::cmd_type    cmd,
   output pcp_pkg::status_type status,
   input  logic signed [11:0]  ctr_col,
   input  logic signed [11:0]  ctr_row,
   input  logic [9:0]          circle_radius,
   input  logic [31:0]         pixel_color,
   input  logic [15:0]         line_stride,
   input  logic [3:0]          bytes_per_pixel,
   output logic signed [12:0]  rsp_point_x,
   output logic signed [12:0]  rsp_point_y,
   output logic                rsp_inside_res,
   output logic [25:0]         rsp_byte_offset,
   output logic [31:0]         rsp_write_color,
   output logic                rsp_last
);

   localparam int IW = 13;

   logic [31:0] angle_ff, angle_in, step_ff, step_in;
   logic        done_ff, done_in;

   logic [29:0] quot_ff, quot_in;
   logic [10:0] rem_ff, rem_in;
   logic [4:0]  dcnt_ff, dcnt_in;

   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic               flip_ff, flip_in;
   logic [4:0]         ccnt_ff, ccnt_in;

   logic signed [33:0] rc_ff, rc_in, rs_ff, rs_in;

   logic signed [12:0] px_ff, px_in, py_ff, py_in;
   logic               ins_ff, ins_in, last_ff, last_in;
   logic [25:0]        off_ff, off_in;
   logic [31:0]        col_ff, col_in;

   logic signed [33:0] z0;
   logic [32:0]        nxt;
   logic               dbit;
   logic [11:0]        trial;
   logic signed [33:0] xs, ys, cq, sq;
   logic signed [33:0] sx, sy;
   logic signed [12:0] qx, qy;
   logic [25:0]        off_calc;

   function automatic logic signed [33:0] to_q20(input logic signed [33:0] v);
      logic signed [33:0] r;
      r = (v + 34'sd512) >>> 10;
      if (r > 34'sd1048576) r = 34'sd1048576;
      if (r < -34'sd1048576) r = -34'sd1048576;
      return r;
   endfunction

   function automatic logic signed [12:0] tdiv(input logic signed [33:0] p);
      logic signed [33:0] a;
      a = p < 0 ? -((-p) >>> 20) : (p >>> 20);
      return a[12:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         step_ff  <= '0;
         done_ff  <= 1'b1;
      end else begin
         angle_ff <= angle_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
      quot_ff <= quot_in; rem_ff <= rem_in; dcnt_ff <= dcnt_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; flip_ff <= flip_in; ccnt_ff <= ccnt_in;
      rc_ff <= rc_in; rs_ff <= rs_in;
      px_ff <= px_in; py_ff <= py_in; ins_ff <= ins_in; last_ff <= last_in;
      off_ff <= off_in; col_ff <= col_in;
   end

   always_comb begin
      quot_in = quot_ff; rem_in = rem_ff; dcnt_in = dcnt_ff;
      dbit = (dcnt_ff == 5'd0);
      trial = {rem_ff, dbit} - {2'b0, circle_radius};
      if (cmd.div_start) begin
         quot_in = '0; rem_in = '0; dcnt_in = '0;
      end else if (cmd.div_step) begin
         if (!trial[11]) begin
            rem_in = trial[10:0];
            quot_in = {quot_ff[28:0], 1'b1};
         end else begin
            rem_in = {rem_ff[9:0], dbit};
            quot_in = {quot_ff[28:0], 1'b0};
         end
         dcnt_in = dcnt_ff + 5'd1;
      end
   end

   assign status.div_done = (dcnt_ff == 5'd29) && cmd.div_step;
   assign status.idle = done_ff;

   always_comb begin
      z0 = {1'b0, angle_ff, 1'b0};
      xs = x_ff >>> ccnt_ff;
      ys = y_ff >>> ccnt_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; flip_in = flip_ff; ccnt_in = ccnt_ff;
      if (cmd.cordic_start) begin
         x_in = pcp_pkg::GAIN_Q30; y_in = '0; ccnt_in = '0; flip_in = 1'b0; z_in = z0;
         if (z0 > pcp_pkg::HALF_PI_Q30 && z0 < pcp_pkg::THREE_HALF_PI_Q30) begin
            z_in = z0 - pcp_pkg::PI_Q30; flip_in = 1'b1;
         end else if (z0 >= pcp_pkg::THREE_HALF_PI_Q30) begin
            z_in = z0 - pcp_pkg::TWO_PI_Q30;
         end
      end else if (cmd.cordic_step) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - pcp_pkg::atan_q30(ccnt_ff);
         end else begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + pcp_pkg::atan_q30(ccnt_ff);
         end
         ccnt_in = ccnt_ff + 5'd1;
      end
   end

   assign status.cordic_done = cmd.cordic_step && (ccnt_ff == 5'(CORDIC_STEPS - 1));

   always_comb begin
      sx = flip_ff ? -x_ff : x_ff;
      sy = flip_ff ? -y_ff : y_ff;
      cq = to_q20(sx);
      sq = to_q20(sy);
      rc_in = cmd.mul ? 34'(cq * $signed({1'b0, circle_radius})) : rc_ff;
      rs_in = cmd.mul ? 34'(sq * $signed({1'b0, circle_radius})) : rs_ff;
   end

   always_comb begin
      qx = 13'(ctr_col) + tdiv(rc_ff);
      qy = 13'(ctr_row) + tdiv(rs_ff);
      off_calc = 26'(32'(unsigned'(qy)) * line_stride + 32'(unsigned'(qx)) * bytes_per_pixel);
      nxt = {1'b0, angle_ff} + {1'b0, step_ff};
      px_in = px_ff; py_in = py_ff; ins_in = ins_ff; off_in = off_ff;
      col_in = col_ff; last_in = last_ff;
      angle_in = angle_ff; step_in = step_ff; done_in = done_ff;
      if (cmd.restart) begin
         angle_in = '0; done_in = 1'b0;
      end
      if (status.div_done) begin
         step_in = (circle_radius == 10'd0) ? pcp_pkg::TWO_PI_Q29 : {2'b0, quot_in};
      end
      if (cmd.point) begin
         px_in = qx; py_in = qy;
         ins_in = qx >= 0 && qx < IW'(IMAGE_WIDTH) && qy >= 0 && qy < IW'(IMAGE_HEIGHT);
         off_in = ins_in ? off_calc : '0;
         col_in = pixel_color;
         last_in = nxt >= {1'b0, pcp_pkg::TWO_PI_Q29};
         angle_in = last_in ? pcp_pkg::TWO_PI_Q29 : nxt[31:0];
         if (last_in) done_in = 1'b1;
      end
   end

   assign rsp_point_x = px_ff;
   assign rsp_point_y = py_ff;
   assign rsp_inside_res = ins_ff;
   assign rsp_byte_offset = off_ff;
   assign rsp_write_color = col_ff;
   assign rsp_last = last_ff;

endmodule

FILE: design/parametric_circle_plotter.sv
// Channel   Direction  Ports
// req       in         req_valid, req_ready, req_restart
// rsp       out        rsp_valid, rsp_ready, point, inside, offset, color, last
// csr       in         APB write/read of six registers at 4*i
// A restart transaction first passes through the shift-subtract step divider.
// Each point then runs CORDIC_STEPS rotation steps, then a multiply step and an offset
// step, after which its result is registered and offered on the rsp channel.
// The next tick is taken in the cycle after the result transaction, so ticks never overlap.
// Synchronous reset returns the plotter to idle with the turn done.
// A result waiting on rsp_ready holds the block; a tick while idle gives nothing.
module parametric_circle_plotter #(
   parameter int IMAGE_WIDTH  = 800,
   parameter int IMAGE_HEIGHT = 800,
   parameter int CORDIC_STEPS = 30
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [12:0] rsp_point_x,
   output logic signed [12:0] rsp_point_y,
   output logic               rsp_inside_res,
   output logic [25:0]        rsp_byte_offset,
   output logic [31:0]        rsp_write_color,
   output logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic signed [11:0] cx_ff, cy_ff;
   logic [9:0]  rad_ff;
   logic [31:0] col_ff;
   logic [15:0] str_ff;
   logic [3:0]  bpp_ff;
   logic        wr;
   logic [2:0]  idx;
   pcp_pkg::cmd_type    cmd;
   pcp_pkg::status_type status;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;
   assign idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= 12'sd400; cy_ff <= 12'sd400; rad_ff <= 10'd200;
         col_ff <= 32'd16711680; str_ff <= 16'd3200; bpp_ff <= 4'd4;
      end else if (wr && paddr[1:0] == 2'b00) begin
         case (idx)
            pcp_pkg::REG_CX:  cx_ff <= pwdata[11:0];
            pcp_pkg::REG_CY:  cy_ff <= pwdata[11:0];
            pcp_pkg::REG_RAD: rad_ff <= pwdata[9:0];
            pcp_pkg::REG_COL: col_ff <= pwdata;
            pcp_pkg::REG_STR: str_ff <= pwdata[15:0];
            pcp_pkg::REG_BPP: bpp_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         pcp_pkg::REG_CX:  prdata = {{20{cx_ff[11]}}, cx_ff};
         pcp_pkg::REG_CY:  prdata = {{20{cy_ff[11]}}, cy_ff};
         pcp_pkg::REG_RAD: prdata = {22'd0, rad_ff};
         pcp_pkg::REG_COL: prdata = col_ff;
         pcp_pkg::REG_STR: prdata = {16'd0, str_ff};
         pcp_pkg::REG_BPP: prdata = {28'd0, bpp_ff};
         default: prdata = '0;
      endcase
   end

   pcp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_restart, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   pcp_datapath #(
      .IMAGE_WIDTH(IMAGE_WIDTH), .IMAGE_HEIGHT(IMAGE_HEIGHT), .CORDIC_STEPS(CORDIC_STEPS)
   ) u_dp (
      .clock, .reset, .cmd, .status,
      .ctr_col(cx_ff), .ctr_row(cy_ff), .circle_radius(rad_ff), .pixel_color(col_ff),
      .line_stride(str_ff), .bytes_per_pixel(bpp_ff),
      .rsp_point_x, .rsp_point_y, .rsp_inside_res, .rsp_byte_offset, .rsp_write_color,
      .rsp_last
   );

   a_excl: assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("ready and result valid together");
   a_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_res |-> rsp_byte_offset == 26'd0)
      else $error("offset set outside image");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_x))
      else $error("result dropped while stalled");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 100;

   class circle_scoreboard;
      typedef struct {
         logic signed [12:0] px;
         logic signed [12:0] py;
         bit in_image;
         bit [25:0] offset;
         bit [31:0] color;
         bit last;
      } plot_point_type;

      longint cx, cy;
      longint unsigned radius, color, stride, bpp;
      bit [31:0] angle, step;
      bit turn_idle;
      plot_point_type pending_points[$];
      int errors, points, turns;

      function new();
         cx = 400;
         cy = 400;
         radius = 200;
         color = 32'h00FF0000;
         stride = 3200;
         bpp = 4;
         angle = 0;
         step = 0;
         turn_idle = 1;
      endfunction

      function void set_register(logic [2:0] idx, bit [31:0] v);
         case (idx)
            pcp_pkg::REG_CX: begin
               cx = longint'(signed'(v[11:0]));
            end
            pcp_pkg::REG_CY: begin
               cy = longint'(signed'(v[11:0]));
            end
            pcp_pkg::REG_RAD: begin
               radius = v[9:0];
            end
            pcp_pkg::REG_COL: begin
               color = v;
            end
            pcp_pkg::REG_STR: begin
               stride = v[15:0];
            end
            pcp_pkg::REG_BPP: begin
               bpp = v[3:0];
            end
            default: begin
            end
         endcase
      endfunction

      function longint arc_table(int i);
         longint head[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                              33543515, 16775850, 8388437, 4194282, 2097149};
         if (i < 10) return head[i];
         if (i >= 30) return 0;
         return (longint'(1) << (30 - i)) - 1;
      endfunction

      function longint round_q20(longint v);
         longint r;
         r = (v + 512) >>> 10;
         if (r > 1048576) r = 1048576;
         if (r < -1048576) r = -1048576;
         return r;
      endfunction

      function void rotate(bit [31:0] ang, output longint c, output longint s);
         longint z, x, y, nx;
         bit flip;
         z = longint'(ang) * 2;
         x = 652032874;
         y = 0;
         flip = 0;
         if (z > 64'sd1686629713 && z < 64'sd5059889139) begin
            z -= 64'sd3373259426;
            flip = 1;
         end else if (z >= 64'sd5059889139) begin
            z -= 64'sd6746518852;
         end
         for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z -= arc_table(i);
            end else begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z += arc_table(i);
            end
            x = nx;
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         c = round_q20(x);
         s = round_q20(y);
      endfunction

      function void note_tick(bit restart);
         longint c, s, xv, yv, r, off;
         longint unsigned nxt;
         plot_point_type p;
         if (restart) begin
            angle = 0;
            step = (radius != 0) ? 32'((64'd1 << 29) / radius) : pcp_pkg::TWO_PI_Q29;
            turn_idle = 0;
         end
         if (turn_idle) return;
         rotate(angle, c, s);
         r = longint'(radius);
         xv = cx + (r * c) / 1048576;
         yv = cy + (r * s) / 1048576;
         p.in_image = xv >= 0 && xv < 800 && yv >= 0 && yv < 800;
         off = p.in_image ? yv * longint'(stride) + xv * longint'(bpp) : 0;
         nxt = longint'(angle) + longint'(step);
         p.last = nxt >= pcp_pkg::TWO_PI_Q29;
         angle = p.last ? pcp_pkg::TWO_PI_Q29 : nxt[31:0];
         if (p.last) turn_idle = 1;
         p.px = xv[12:0];
         p.py = yv[12:0];
         p.offset = off[25:0];
         p.color = color[31:0];
         pending_points.push_back(p);
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_point(logic signed [12:0] px, logic signed [12:0] py, logic in_image,
                       logic [25:0] offset, logic [31:0] wcolor, logic last);
         plot_point_type e;
         if (pending_points.size() == 0) begin
            report_mismatch($sformatf("unexpected point (%0d,%0d)", px, py));
            return;
         end
         e = pending_points.pop_front();
         points++;
         if (last) turns++;
         if (px !== e.px) report_mismatch($sformatf("x %0d, expected %0d", px, e.px));
         if (py !== e.py) report_mismatch($sformatf("y %0d, expected %0d", py, e.py));
         if (in_image !== e.in_image)
            report_mismatch($sformatf("inside %b, expected %b", in_image, e.in_image));
         if (offset !== e.offset)
            report_mismatch($sformatf("offset %0h, expected %0h", offset, e.offset));
         if (wcolor !== e.color)
            report_mismatch($sformatf("color %0h, expected %0h", wcolor, e.color));
         if (last !== e.last) report_mismatch($sformatf("last %b, expected %b", last, e.last));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic req_restart = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [12:0] rsp_point_x;
   logic signed [12:0] rsp_point_y;
   logic rsp_inside_res;
   logic [25:0] rsp_byte_offset;
   logic [31:0] rsp_write_color;
   logic rsp_last;
   logic psel = 0;
   logic penable = 0;
   logic pwrite = 0;
   logic [4:0] paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic pready;

   circle_scoreboard plot_board = new();
   bit quiet = 0;
   int ticks_sent = 0;
   int stall_left = 0;
   int idle_cycles = 0;

   parametric_circle_plotter DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .rsp_inside_res(rsp_inside_res), .rsp_byte_offset(rsp_byte_offset),
      .rsp_write_color(rsp_write_color), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int n;
      if (quiet) return 0;
      n = $urandom_range(0, 99);
      if (n < 60) return 0;
      if (n < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic write_register(logic [2:0] idx, bit [31:0] v);
      @(posedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      plot_board.set_register(idx, v);
   endtask

   task automatic send_tick(bit restart);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      plot_board.note_tick(restart);
      ticks_sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (plot_board.pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic plot_turn(int extra);
      int n;
      n = 7 * int'(plot_board.radius) + 2;
      if (n > 80) n = $urandom_range(2, 80);
      send_tick(1);
      repeat (n + extra) send_tick(0);
   endtask

   task automatic random_traffic(int budget);
      int start;
      start = ticks_sent;
      while (ticks_sent - start < budget) begin
         if ($urandom_range(0, 9) < 7) begin
            plot_turn(int'($urandom_range(0, 2)));
         end else begin
            repeat ($urandom_range(1, 5)) send_tick(1'($urandom_range(0, 1)));
         end
      end
   endtask

   function automatic bit [31:0] pick_center();
      case ($urandom_range(0, 5))
         0: return 32'h800;
         1: return 32'h7FF;
         2: return $urandom();
         default: return $urandom_range(0, 799);
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         plot_board.check_point(rsp_point_x, rsp_point_y, rsp_inside_res,
                                rsp_byte_offset, rsp_write_color, rsp_last);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
         if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d points outstanding.",
                     plot_board.pending_points.size());
            $display("testbench failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;

      send_tick(0);
      send_tick(1);
      repeat (3) send_tick(0);
      send_tick(1);
      repeat (2) send_tick(0);
      drain();
      write_register(pcp_pkg::REG_RAD, 0);
      write_register(pcp_pkg::REG_CX, 32'h800);
      write_register(pcp_pkg::REG_CY, 32'h7FF);
      send_tick(1);
      send_tick(0);
      drain();
      write_register(pcp_pkg::REG_RAD, 1);
      write_register(pcp_pkg::REG_CX, 32'h7FF);
      write_register(pcp_pkg::REG_CY, 32'h800);
      write_register(pcp_pkg::REG_STR, 32'hFFFF);
      write_register(pcp_pkg::REG_BPP, 32'hF);
      write_register(pcp_pkg::REG_COL, 32'hFFFFFFFF);
      send_tick(1);
      repeat (8) send_tick(0);
      drain();
      write_register(pcp_pkg::REG_RAD, 1023);
      write_register(pcp_pkg::REG_CX, 0);
      write_register(pcp_pkg::REG_CY, 0);
      write_register(pcp_pkg::REG_STR, 0);
      write_register(pcp_pkg::REG_BPP, 0);
      send_tick(1);
      repeat (3) send_tick(0);
      drain();
      write_register(pcp_pkg::REG_RAD, 3);
      write_register(pcp_pkg::REG_CX, 799);
      write_register(pcp_pkg::REG_CY, 799);
      write_register(pcp_pkg::REG_BPP, 8);
      write_register(pcp_pkg::REG_STR, 32'hFFFF);
      write_register(pcp_pkg::REG_COL, 0);
      send_tick(1);
      repeat (23) send_tick(0);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         quiet = (phase % 4 == 3);
         write_register(pcp_pkg::REG_CX, pick_center());
         write_register(pcp_pkg::REG_CY, pick_center());
         write_register(pcp_pkg::REG_RAD, ($urandom_range(0, 9) == 0) ? $urandom() :
                                          $urandom_range(0, 12));
         write_register(pcp_pkg::REG_COL, $urandom());
         write_register(pcp_pkg::REG_STR, ($urandom_range(0, 3) == 0) ? 32'hFFFF : $urandom());
         write_register(pcp_pkg::REG_BPP, $urandom_range(0, 15));
         random_traffic(180);
         drain();
      end

      $display("Sent %0d ticks across directed and eight random register settings.",
               ticks_sent);
      $display("Checked %0d plotted points, %0d of them closing a full turn.",
               plot_board.points, plot_board.turns);
      if (plot_board.errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

FILE: parametric_circle_plotter.f
design/pcp_pkg.sv
design/pcp_ctrl.sv
design/pcp_datapath.sv
design/parametric_circle_plotter.sv
tb/sv/testbench.sv
